// ----- hdl/utf8_single_line_validator_core_assert.svh -----
// assertion macros for the utf-8 single-line validator core
`ifndef UTF8_SINGLE_LINE_VALIDATOR_CORE_ASSERT_SVH
`define UTF8_SINGLE_LINE_VALIDATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UTF8V_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UTF8V_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/utf8v_pkg.sv -----
// types, status codes and range checks shared by the utf-8 validator
package utf8v_pkg;

    localparam int unsigned CpWidth = 21;

    localparam logic [1:0] STATUS_NONE      = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_LINE_BRK  = 2'd2;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;

    localparam logic [CpWidth-1:0] MIN_CP3   = 21'h00800;
    localparam logic [CpWidth-1:0] MIN_CP4   = 21'h10000;
    localparam logic [CpWidth-1:0] SURR_LO   = 21'h0D800;
    localparam logic [CpWidth-1:0] SURR_HI   = 21'h0DFFF;
    localparam logic [CpWidth-1:0] MAX_CP    = 21'h10FFFF;
    localparam logic [CpWidth-1:0] CP_LF     = 21'h0000A;
    localparam logic [CpWidth-1:0] CP_CR     = 21'h0000D;
    localparam logic [CpWidth-1:0] CP_NEL    = 21'h00085;
    localparam logic [CpWidth-1:0] CP_LSEP   = 21'h02028;
    localparam logic [CpWidth-1:0] CP_PSEP   = 21'h02029;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic               char_done;
        logic [1:0]         status;
        logic               text_done;
    } out_item_t;

    // verdict on a finished character
    function automatic logic [1:0] judge_cp(input logic [CpWidth-1:0] v,
                                            input logic [2:0] len);
        logic [1:0] verdict;
        verdict = STATUS_NONE;
        if ((len == 3'd3 && v < MIN_CP3) || (len == 3'd4 && v < MIN_CP4) ||
            (v >= SURR_LO && v <= SURR_HI) || v > MAX_CP) begin
            verdict = STATUS_MALFORMED;
        end else if (v == CP_LF || v == CP_CR || v == CP_NEL ||
                     v == CP_LSEP || v == CP_PSEP) begin
            verdict = STATUS_LINE_BRK;
        end
        return verdict;
    endfunction

endpackage

// ----- hdl/utf8_single_line_validator_core.sv -----
// top level of the streaming utf-8 single-line validator
//
//  channel  | dir | payload     | handshake
//  ---------+-----+-------------+-----------------
//  s_       | in  | in_item_t   | s_valid/s_ready
//  m_       | out | out_item_t  | m_valid/m_ready
//
// one byte per cycle sustained while m_ is not stalled; a result reaches m_
// through the input register, then the result register
// decode state advances only when a byte moves from the input register to
// the result register, so stalls on m_ hold everything in place
// aresetn clears both valid flags and the decode state; no clearing pass
`include "utf8_single_line_validator_core_assert.svh"

module utf8_single_line_validator_core import utf8v_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic               in_valid_reg;
    in_item_t           in_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic [1:0]         remain_reg, remain_next;
    logic [2:0]         seq_len_reg, seq_len_next;
    logic [CpWidth-1:0] partial_reg, partial_next;
    logic [1:0]         error_reg, error_next;

    logic               advance;
    logic               complete;
    logic [CpWidth-1:0] char_val;
    logic [2:0]         char_len;
    logic [1:0]         verdict;
    out_item_t          result;
    logic [7:0]         b;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign b       = in_reg.data_byte;

    always_comb begin
        remain_next  = remain_reg;
        seq_len_next = seq_len_reg;
        partial_next = partial_reg;
        error_next   = error_reg;
        complete     = 1'b0;
        char_val     = '0;
        char_len     = 3'd0;
        verdict      = STATUS_NONE;
        result       = '0;

        if (error_reg == STATUS_NONE) begin
            if (remain_reg == 2'd0) begin
                if (!b[7]) begin
                    char_val = {13'd0, b};
                    char_len = 3'd1;
                    complete = 1'b1;
                end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                    partial_next = {16'd0, b[4:0]};
                    seq_len_next = 3'd2;
                    remain_next  = 2'd1;
                end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                    partial_next = {17'd0, b[3:0]};
                    seq_len_next = 3'd3;
                    remain_next  = 2'd2;
                end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                    partial_next = {18'd0, b[2:0]};
                    seq_len_next = 3'd4;
                    remain_next  = 2'd3;
                end else begin
                    error_next = STATUS_MALFORMED;
                end
            end else if (b[7:6] != 2'b10) begin
                error_next = STATUS_MALFORMED;
            end else begin
                partial_next = {partial_reg[CpWidth-7:0], b[5:0]};
                remain_next  = remain_reg - 2'd1;
                if (remain_reg == 2'd1) begin
                    char_val = partial_next;
                    char_len = seq_len_reg;
                    complete = 1'b1;
                end
            end

            if (complete) begin
                verdict      = judge_cp(char_val, char_len);
                remain_next  = 2'd0;
                seq_len_next = 3'd0;
                partial_next = '0;
                if (verdict != STATUS_NONE) begin
                    error_next = verdict;
                end else begin
                    result.code_point = char_val;
                    result.char_done  = 1'b1;
                end
            end

            // text ends inside an open sequence
            if (in_reg.last_byte && error_next == STATUS_NONE && remain_next != 2'd0) begin
                error_next = STATUS_MALFORMED;
            end
        end

        result.status    = error_next;
        result.text_done = in_reg.last_byte;

        if (in_reg.last_byte) begin
            remain_next  = 2'd0;
            seq_len_next = 3'd0;
            partial_next = '0;
            error_next   = STATUS_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            remain_reg    <= 2'd0;
            seq_len_reg   <= 3'd0;
            partial_reg   <= '0;
            error_reg     <= STATUS_NONE;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                remain_reg    <= remain_next;
                seq_len_reg   <= seq_len_next;
                partial_reg   <= partial_next;
                error_reg     <= error_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    `UTF8V_ASSERT_NOW(a_char_clean, aclk, aresetn,
        out_valid_reg && out_reg.char_done, out_reg.status == STATUS_NONE,
        "character reported with an error status")
    `UTF8V_ASSERT_NOW(a_cp_zero, aclk, aresetn,
        out_valid_reg && !out_reg.char_done, out_reg.code_point == '0,
        "code point not zero without a character")
    `UTF8V_ASSERT_NEXT(a_end_clears, aclk, aresetn,
        advance && in_reg.last_byte,
        remain_reg == 2'd0 && seq_len_reg == 3'd0 && error_reg == STATUS_NONE,
        "decode state not cleared after last byte")
    `UTF8V_ASSERT_NEXT(a_err_sticky, aclk, aresetn,
        error_reg != STATUS_NONE && !(advance && in_reg.last_byte),
        error_reg == $past(error_reg),
        "error status changed before end of text")

endmodule

// ----- dv/tb_utf8_single_line_validator_core.sv -----
// testbench for the streaming utf-8 single-line validator core
module tb_utf8_single_line_validator_core;
    import utf8v_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    utf8_single_line_validator_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    typedef struct packed {
        logic [7:0]         data_byte;
        logic               last_byte;
        logic               typed;
        logic [CpWidth-1:0] cp;
        logic               done;
        logic [1:0]         status;
    } dir_row_t;

    // fixed opening texts; typed rows carry their result, the rest use the decoder model
    dir_row_t directed_rows [25] = '{
        '{8'h00, 1'b1, 1'b1, 21'h000000, 1'b1, STATUS_NONE},
        '{8'h7F, 1'b1, 1'b1, 21'h00007F, 1'b1, STATUS_NONE},
        '{8'hFF, 1'b1, 1'b1, 21'h000000, 1'b0, STATUS_MALFORMED},
        '{8'h80, 1'b1, 1'b1, 21'h000000, 1'b0, STATUS_MALFORMED},
        '{8'hC2, 1'b0, 1'b0, 21'h000000, 1'b0, STATUS_NONE},
        '{8'h41, 1'b1, 1'b1, 21'h000000, 1'b0, STATUS_MALFORMED},
        '{8'h0D, 1'b0, 1'b1, 21'h000000, 1'b0, STATUS_LINE_BRK},
        '{8'h41, 1'b1, 1'b1, 21'h000000, 1'b0, STATUS_LINE_BRK},
        '{8'hE2, 1'b0, 1'b0, 21'h000000, 1'b0, STATUS_NONE},
        '{8'h80, 1'b0, 1'b0, 21'h000000, 1'b0, STATUS_NONE},
        '{8'hA8, 1'b1, 1'b1, 21'h000000, 1'b0, STATUS_LINE_BRK},
        '{8'hED, 1'b0, 1'b0, 21'h000000, 1'b0, STATUS_NONE},
        '{8'hA0, 1'b0, 1'b0, 21'h000000, 1'b0, STATUS_NONE},
        '{8'h80, 1'b1, 1'b1, 21'h000000, 1'b0, STATUS_MALFORMED},
        '{8'hF4, 1'b0, 1'b0, 21'h000000, 1'b0, STATUS_NONE},
        '{8'h8F, 1'b0, 1'b0, 21'h000000, 1'b0, STATUS_NONE},
        '{8'hBF, 1'b0, 1'b0, 21'h000000, 1'b0, STATUS_NONE},
        '{8'hBF, 1'b1, 1'b1, 21'h10FFFF, 1'b1, STATUS_NONE},
        '{8'hE2, 1'b0, 1'b0, 21'h000000, 1'b0, STATUS_NONE},
        '{8'h82, 1'b1, 1'b1, 21'h000000, 1'b0, STATUS_MALFORMED},
        '{8'hF5, 1'b0, 1'b1, 21'h000000, 1'b0, STATUS_MALFORMED},
        '{8'hC2, 1'b1, 1'b1, 21'h000000, 1'b0, STATUS_MALFORMED},
        '{8'hE0, 1'b0, 1'b0, 21'h000000, 1'b0, STATUS_NONE},
        '{8'h80, 1'b0, 1'b0, 21'h000000, 1'b0, STATUS_NONE},
        '{8'h80, 1'b1, 1'b1, 21'h000000, 1'b0, STATUS_MALFORMED}
    };

    int unsigned idle_by_seg  [5] = '{0, 58, 0, 16, 58};
    int unsigned stall_by_seg [5] = '{0, 0, 58, 16, 0};

    // decoder model state
    logic [1:0]         cont_left = '0;
    logic [2:0]         seq_bytes = '0;
    logic [CpWidth-1:0] acc_cp = '0;
    logic [1:0]         sticky_err = STATUS_NONE;

    out_item_t   decoded_q [$];
    logic [7:0]  text_bytes [$];
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned random_sent = 0;

    function automatic out_item_t decode_byte(input in_item_t item);
        out_item_t          r;
        logic [7:0]         b;
        logic [CpWidth-1:0] v;
        logic [2:0]         len;
        logic               complete;
        r = '0;
        b = item.data_byte;
        v = '0;
        len = '0;
        complete = 1'b0;
        if (sticky_err == STATUS_NONE) begin
            if (cont_left == 2'd0) begin
                if (!b[7]) begin
                    v = {13'd0, b};
                    len = 3'd1;
                    complete = 1'b1;
                end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                    acc_cp = {16'd0, b[4:0]};
                    seq_bytes = 3'd2;
                    cont_left = 2'd1;
                end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                    acc_cp = {17'd0, b[3:0]};
                    seq_bytes = 3'd3;
                    cont_left = 2'd2;
                end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                    acc_cp = {18'd0, b[2:0]};
                    seq_bytes = 3'd4;
                    cont_left = 2'd3;
                end else begin
                    sticky_err = STATUS_MALFORMED;
                end
            end else if (b[7:6] != 2'b10) begin
                sticky_err = STATUS_MALFORMED;
            end else begin
                acc_cp = {acc_cp[CpWidth-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    v = acc_cp;
                    len = seq_bytes;
                    complete = 1'b1;
                end
            end
            if (complete) begin
                cont_left = '0;
                seq_bytes = '0;
                acc_cp = '0;
                if ((len == 3'd3 && v < MIN_CP3) || (len == 3'd4 && v < MIN_CP4) ||
                    (v >= SURR_LO && v <= SURR_HI) || v > MAX_CP) begin
                    sticky_err = STATUS_MALFORMED;
                end else if (v == CP_LF || v == CP_CR || v == CP_NEL ||
                             v == CP_LSEP || v == CP_PSEP) begin
                    sticky_err = STATUS_LINE_BRK;
                end else begin
                    r.code_point = v;
                    r.char_done = 1'b1;
                end
            end
            // sequence cut off by the end of the text
            if (item.last_byte && sticky_err == STATUS_NONE && cont_left != 2'd0) begin
                sticky_err = STATUS_MALFORMED;
            end
        end
        r.status = sticky_err;
        r.text_done = item.last_byte;
        if (item.last_byte) begin
            cont_left = '0;
            seq_bytes = '0;
            acc_cp = '0;
            sticky_err = STATUS_NONE;
        end
        return r;
    endfunction

    function automatic void put_byte(input logic [7:0] v);
        text_bytes = {text_bytes, v};
    endfunction

    function automatic void add_encoded(input logic [CpWidth-1:0] c, input int n);
        case (n)
            1: put_byte(c[7:0]);
            2: begin
                put_byte({3'b110, c[10:6]});
                put_byte({2'b10, c[5:0]});
            end
            3: begin
                put_byte({4'b1110, c[15:12]});
                put_byte({2'b10, c[11:6]});
                put_byte({2'b10, c[5:0]});
            end
            default: begin
                put_byte({5'b11110, c[20:18]});
                put_byte({2'b10, c[17:12]});
                put_byte({2'b10, c[11:6]});
                put_byte({2'b10, c[5:0]});
            end
        endcase
    endfunction

    // a valid character that is not a line break, encoded in n bytes
    function automatic logic [CpWidth-1:0] pick_cp(input int n);
        logic [CpWidth-1:0] c;
        case (n)
            1: begin
                c = CpWidth'($urandom_range(0, 'h7F));
                if (c == CP_LF || c == CP_CR) c = c + 21'd1;
            end
            2: begin
                c = CpWidth'($urandom_range('h80, 'h7FF));
                if (c == CP_NEL) c = c + 21'd1;
            end
            3: begin
                c = CpWidth'($urandom_range('h800, 'hFFFF));
                if (c >= SURR_LO && c <= SURR_HI) c = c ^ 21'h2000;
                if (c == CP_LSEP || c == CP_PSEP) c = c + 21'd2;
            end
            default: c = CpWidth'($urandom_range('h10000, 'h10FFFF));
        endcase
        return c;
    endfunction

    task automatic add_random_char();
        int unsigned roll;
        int          n;
        int          start;
        logic [7:0]  b;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            add_encoded(pick_cp(1), 1);
        end else if (roll < 70) begin
            n = $urandom_range(2, 4);
            add_encoded(pick_cp(n), n);
        end else if (roll < 74) begin
            case ($urandom_range(0, 4))
                0: add_encoded(CP_LF, 1);
                1: add_encoded(CP_CR, 1);
                2: add_encoded(CP_NEL, 2);
                3: add_encoded(CP_LSEP, 3);
                default: add_encoded(CP_PSEP, 3);
            endcase
        end else if (roll < 78) begin
            // overlong, surrogate or beyond the last code point
            case ($urandom_range(0, 3))
                0: add_encoded(CpWidth'($urandom_range(0, 'h7FF)), 3);
                1: add_encoded(CpWidth'($urandom_range(0, 'hFFFF)), 4);
                2: add_encoded(CpWidth'($urandom_range('hD800, 'hDFFF)), 3);
                default: add_encoded(CpWidth'($urandom_range('h110000, 'h13FFFF)), 4);
            endcase
        end else if (roll < 81) begin
            case ($urandom_range(0, 2))
                0: b = 8'($urandom_range('h80, 'hBF));
                1: b = 8'($urandom_range('hC0, 'hC1));
                default: b = 8'($urandom_range('hF5, 'hFF));
            endcase
            put_byte(b);
        end else if (roll < 85) begin
            n = $urandom_range(2, 4);
            start = text_bytes.size();
            add_encoded(pick_cp(n), n);
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            text_bytes[start + $urandom_range(1, n - 1)] = b;
        end else begin
            add_encoded(CpWidth'($urandom_range('h20, 'h7E)), 1);
        end
    endtask

    task automatic build_text();
        int n;
        text_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 10)) add_random_char();
            // text ending inside a multi-byte sequence
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(2, 4);
                add_encoded(pick_cp(n), n);
                repeat ($urandom_range(1, n - 1)) void'(text_bytes.pop_back());
            end
        end
    endtask

    // called at a rising edge; returns at the edge where the request is taken
    task automatic push_byte(input in_item_t item, input logic typed, input out_item_t want);
        out_item_t predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        predicted = decode_byte(item);
        decoded_q = {decoded_q, (typed ? want : predicted)};
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (decoded_q.size() != 0);
    endtask

    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    initial begin : result_monitor
        out_item_t got;
        out_item_t want;
        logic      taken;
        forever begin
            @(negedge aclk);
            taken = aresetn && m_valid && m_ready;
            got = m_data;
            @(posedge aclk);
            if (taken) begin
                if (decoded_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none expected, expected nothing, got %0h",
                             $time, got);
                end else begin
                    want = decoded_q.pop_front();
                    note_field("code_point", 32'(want.code_point), 32'(got.code_point));
                    note_field("char_done", 32'(want.char_done), 32'(got.char_done));
                    note_field("status", 32'(want.status), 32'(got.status));
                    note_field("text_done", 32'(want.text_done), 32'(got.text_done));
                end
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin : stimulus
        in_item_t  item;
        out_item_t want;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            item.data_byte = directed_rows[i].data_byte;
            item.last_byte = directed_rows[i].last_byte;
            want.code_point = directed_rows[i].cp;
            want.char_done = directed_rows[i].done;
            want.status = directed_rows[i].status;
            want.text_done = directed_rows[i].last_byte;
            push_byte(item, directed_rows[i].typed, want);
        end

        for (int seg = 0; seg < 5; seg++) begin
            // hold off until every pending result is out
            wait_drained();
            idle_pct = idle_by_seg[seg];
            stall_pct = stall_by_seg[seg];
            while (random_sent < (seg + 1) * 240) begin
                build_text();
                foreach (text_bytes[i]) begin
                    item.data_byte = text_bytes[i];
                    item.last_byte = (i == text_bytes.size() - 1);
                    push_byte(item, 1'b0, '0);
                    random_sent++;
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
